// ===== rtl/bmis_pkg.sv =====
`timescale 1ns / 1ps
package bmis_pkg;

  localparam int MEM_WORDS_DEF = 128;
  localparam int WORD_BITS_DEF = 32;

  localparam int DATA_BITS  = 32;
  localparam int LADDR_BITS = 7;
  localparam int PC_BITS    = 7;

  localparam logic FUNC_LOAD = 1'b0;

  localparam int OP_MEM_READ  = 0;
  localparam int OP_MEM_WRITE = 1;
  localparam int OP_BRANCH    = 10;
  localparam int OP_BUS_MAR   = 11;
  localparam int OP_BUS_MBR   = 12;
  localparam int OP_BUS_PC    = 13;
  localparam int OP_BUS_D     = 14;
  localparam int OP_BUS_E     = 15;
  localparam int OP_MAR_BUS   = 21;
  localparam int OP_MBR_BUS   = 22;
  localparam int OP_PC_BUS    = 23;
  localparam int OP_D_BUS     = 24;
  localparam int OP_E_BUS     = 25;
  localparam int OP_BUS_P     = 31;
  localparam int OP_BUS_Q     = 32;
  localparam int OP_ADD       = 33;
  localparam int OP_SUB       = 34;
  localparam int OP_MUL       = 35;
  localparam int OP_DIV       = 36;
  localparam int OP_INPUT     = 47;
  localparam int OP_OUTPUT    = 48;
  localparam int OP_HALT      = 49;
  localparam int OP_IMM_BASE  = 500;
  localparam int OP_IMM_LAST  = 599;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_ARITH,
    ST_DONE
  } state_t;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_req_t;

endpackage

// ===== rtl/bmis_ram.sv =====
`timescale 1ns / 1ps
module bmis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bmis_muldiv.sv =====
`timescale 1ns / 1ps
module bmis_muldiv
  import bmis_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  md_req_t              req,
  input  logic [WORD_BITS-1:0] opa,
  input  logic [WORD_BITS-1:0] opb,
  output logic                 done,
  output logic [WORD_BITS-1:0] result
);

  localparam int CNT_BITS = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] x_r, y_r, acc_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic                 busy_r, done_r, neg_r, divz_r;
  md_op_t               op_r;

  logic [WORD_BITS:0]   shifted, trial;

  assign shifted = {acc_r, x_r[WORD_BITS-1]};
  assign trial   = shifted - {1'b0, y_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_BITS'(WORD_BITS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r   <= req.op;
      cnt_r  <= '0;
      acc_r  <= '0;
      neg_r  <= opa[WORD_BITS-1] ^ opb[WORD_BITS-1];
      divz_r <= (opb == '0);
      if (req.op == MD_DIV) begin
        x_r <= opa[WORD_BITS-1] ? -opa : opa;
        y_r <= opb[WORD_BITS-1] ? -opb : opb;
      end else begin
        x_r <= opa;
        y_r <= opb;
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_BITS'(1);
      if (op_r == MD_DIV) begin
        if (!trial[WORD_BITS]) begin
          acc_r <= trial[WORD_BITS-1:0];
          x_r   <= {x_r[WORD_BITS-2:0], 1'b1};
        end else begin
          acc_r <= shifted[WORD_BITS-1:0];
          x_r   <= {x_r[WORD_BITS-2:0], 1'b0};
        end
      end else begin
        if (y_r[0]) begin
          acc_r <= acc_r + x_r;
        end
        x_r <= {x_r[WORD_BITS-2:0], 1'b0};
        y_r <= {1'b0, y_r[WORD_BITS-1:1]};
      end
    end
  end

  always_comb begin
    if (op_r == MD_MUL) begin
      result = acc_r;
    end else if (divz_r) begin
      result = '0;
    end else if (neg_r) begin
      result = -x_r;
    end else begin
      result = x_r;
    end
  end

  assign done = done_r;

endmodule

// ===== rtl/bus_machine_instruction_step.sv =====
`timescale 1ns / 1ps
// Order: a load is written at its accepting edge; a step goes from ST_IDLE through ST_EXEC
// (then ST_LOAD for a memory read, ST_ARITH for multiply/divide) to ST_DONE, or straight to
// ST_DONE when halted, and raises out_valid from there. Throughput: a load every cycle; a new
// item is taken only after a step has left ST_DONE, which waits while out_ready is low.
// Reset: synchronous active-low rst_n clears the machine registers, flag, halt, state and
// out_valid; the word memory is not cleared. MEM_WORDS is taken as a power of two.
module bus_machine_instruction_step
  import bmis_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_func,
  input  logic [LADDR_BITS-1:0] in_load_address,
  input  logic signed [DATA_BITS-1:0] in_data_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_has_output,
  output logic signed [DATA_BITS-1:0] out_output_value,
  output logic                  out_halted,
  output logic [PC_BITS-1:0]    out_program_counter
);

  localparam int ADDR_BITS = $clog2(MEM_WORDS);

  state_t state_r, state_nxt;

  logic [WORD_BITS-1:0] bus_r, mar_r, mbr_r, pc_r, d_r, e_r, p_r, q_r;
  logic [WORD_BITS-1:0] bus_nxt, mar_nxt, mbr_nxt, pc_nxt, d_nxt, e_nxt, p_nxt, q_nxt;
  logic                 flag_r, flag_nxt, stop_r, stop_nxt;
  logic [WORD_BITS-1:0] data_r, data_nxt;
  logic                 res_has_r, res_has_nxt;
  logic [WORD_BITS-1:0] res_val_r, res_val_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_has_r;
  logic [DATA_BITS-1:0] out_val_r;
  logic                 out_halt_r;
  logic [PC_BITS-1:0]   out_pc_r;
  logic                 out_load;

  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  md_req_t              md_req;
  logic                 md_done;
  logic [WORD_BITS-1:0] md_result;

  logic                 accept;
  logic [WORD_BITS-1:0] in_data_ext, word, pc_inc, sum, diff;
  logic [ADDR_BITS+LADDR_BITS-1:0] laddr_wide;
  logic [ADDR_BITS+PC_BITS-1:0]    pc_wide;
  logic [WORD_BITS+DATA_BITS-1:0]  data_wide, outv_wide;

  assign accept      = in_valid && in_ready;
  assign data_wide   = {{WORD_BITS{in_data_value[DATA_BITS-1]}}, in_data_value};
  assign in_data_ext = data_wide[WORD_BITS-1:0];
  assign laddr_wide  = {{ADDR_BITS{1'b0}}, in_load_address};
  assign pc_wide     = {{PC_BITS{1'b0}}, pc_r[ADDR_BITS-1:0]};
  assign outv_wide   = {{DATA_BITS{1'b0}}, res_val_r};
  assign word        = ram_rdata;
  assign pc_inc      = pc_r + WORD_BITS'(1);
  assign sum         = p_r + q_r;
  assign diff        = p_r - q_r;

  bmis_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  bmis_muldiv #(
    .WORD_BITS(WORD_BITS)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .opa   (p_r),
    .opb   (q_r),
    .done  (md_done),
    .result(md_result)
  );

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bus_r       <= '0;
      mar_r       <= '0;
      mbr_r       <= '0;
      pc_r        <= '0;
      d_r         <= '0;
      e_r         <= '0;
      p_r         <= '0;
      q_r         <= '0;
      flag_r      <= 1'b0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bus_r       <= bus_nxt;
      mar_r       <= mar_nxt;
      mbr_r       <= mbr_nxt;
      pc_r        <= pc_nxt;
      d_r         <= d_nxt;
      e_r         <= e_nxt;
      p_r         <= p_nxt;
      q_r         <= q_nxt;
      flag_r      <= flag_nxt;
      stop_r      <= stop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r    <= data_nxt;
    res_has_r <= res_has_nxt;
    res_val_r <= res_val_nxt;
    if (out_load) begin
      out_has_r  <= res_has_r;
      out_val_r  <= outv_wide[DATA_BITS-1:0];
      out_halt_r <= stop_r;
      out_pc_r   <= pc_wide[PC_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bus_nxt       = bus_r;
    mar_nxt       = mar_r;
    mbr_nxt       = mbr_r;
    pc_nxt        = pc_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    flag_nxt      = flag_r;
    stop_nxt      = stop_r;
    data_nxt      = data_r;
    res_has_nxt   = res_has_r;
    res_val_nxt   = res_val_r;
    ram_we        = 1'b0;
    ram_addr      = pc_r[ADDR_BITS-1:0];
    ram_wdata     = in_data_ext;
    md_req.start  = 1'b0;
    md_req.op     = MD_MUL;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          data_nxt    = in_data_ext;
          res_has_nxt = 1'b0;
          res_val_nxt = '0;
          if (in_func == FUNC_LOAD) begin
            ram_we   = 1'b1;
            ram_addr = laddr_wide[ADDR_BITS-1:0];
          end else if (stop_r) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        pc_nxt    = pc_inc;
        state_nxt = ST_DONE;
        if (!word[WORD_BITS-1]) begin
          case (word)
            WORD_BITS'(OP_MEM_READ): begin
              ram_addr  = mar_r[ADDR_BITS-1:0];
              state_nxt = ST_LOAD;
            end
            WORD_BITS'(OP_MEM_WRITE): begin
              ram_we    = 1'b1;
              ram_addr  = mar_r[ADDR_BITS-1:0];
              ram_wdata = mbr_r;
            end
            WORD_BITS'(OP_BRANCH): begin
              if (!flag_r) begin
                pc_nxt = bus_r;
              end
            end
            WORD_BITS'(OP_BUS_MAR): mar_nxt = bus_r;
            WORD_BITS'(OP_BUS_MBR): mbr_nxt = bus_r;
            WORD_BITS'(OP_BUS_PC):  pc_nxt  = bus_r;
            WORD_BITS'(OP_BUS_D):   d_nxt   = bus_r;
            WORD_BITS'(OP_BUS_E):   e_nxt   = bus_r;
            WORD_BITS'(OP_MAR_BUS): bus_nxt = mar_r;
            WORD_BITS'(OP_MBR_BUS): bus_nxt = mbr_r;
            WORD_BITS'(OP_PC_BUS):  bus_nxt = pc_inc;
            WORD_BITS'(OP_D_BUS):   bus_nxt = d_r;
            WORD_BITS'(OP_E_BUS):   bus_nxt = e_r;
            WORD_BITS'(OP_BUS_P):   p_nxt   = bus_r;
            WORD_BITS'(OP_BUS_Q):   q_nxt   = bus_r;
            WORD_BITS'(OP_ADD): begin
              bus_nxt  = sum;
              flag_nxt = sum[WORD_BITS-1];
            end
            WORD_BITS'(OP_SUB): begin
              bus_nxt  = diff;
              flag_nxt = diff[WORD_BITS-1];
            end
            WORD_BITS'(OP_MUL): begin
              md_req.start = 1'b1;
              md_req.op    = MD_MUL;
              state_nxt    = ST_ARITH;
            end
            WORD_BITS'(OP_DIV): begin
              md_req.start = 1'b1;
              md_req.op    = MD_DIV;
              state_nxt    = ST_ARITH;
            end
            WORD_BITS'(OP_INPUT):  bus_nxt = data_r;
            WORD_BITS'(OP_OUTPUT): begin
              res_has_nxt = 1'b1;
              res_val_nxt = bus_r;
            end
            WORD_BITS'(OP_HALT): stop_nxt = 1'b1;
            default: begin
              if (word >= WORD_BITS'(OP_IMM_BASE) && word <= WORD_BITS'(OP_IMM_LAST)) begin
                bus_nxt = word - WORD_BITS'(OP_IMM_BASE);
              end
            end
          endcase
        end
      end
      ST_LOAD: begin
        mbr_nxt   = ram_rdata;
        state_nxt = ST_DONE;
      end
      ST_ARITH: begin
        if (md_done) begin
          bus_nxt   = md_result;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_has_output      = out_has_r;
  assign out_output_value    = out_val_r;
  assign out_halted          = out_halt_r;
  assign out_program_counter = out_pc_r;

endmodule

// ===== tb/bus_machine_instruction_step_tb.sv =====
`timescale 1ns / 1ps
module bus_machine_instruction_step_tb;
  import bmis_pkg::*;

  localparam int MEMW = MEM_WORDS_DEF;
  localparam int RANDOM_ITEMS = 1550;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 2 * WORD_BITS_DEF + 8;
  localparam logic FUNC_STEP = ~FUNC_LOAD;

  typedef struct packed {
    logic                  func;
    logic [LADDR_BITS-1:0] addr;
    logic [DATA_BITS-1:0]  data;
  } bus_item_t;

  typedef struct packed {
    logic                 has_output;
    logic [DATA_BITS-1:0] value;
    logic                 halted;
    logic [PC_BITS-1:0]   pc;
  } step_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = 1'b0;
  logic [LADDR_BITS-1:0] in_load_address = '0;
  logic signed [DATA_BITS-1:0] in_data_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_has_output;
  logic signed [DATA_BITS-1:0] out_output_value;
  logic out_halted;
  logic [PC_BITS-1:0] out_program_counter;

  bus_machine_instruction_step dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_load_address     (in_load_address),
    .in_data_value       (in_data_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_has_output      (out_has_output),
    .out_output_value    (out_output_value),
    .out_halted          (out_halted),
    .out_program_counter (out_program_counter)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bus_item_t    pending[$];
  step_report_t step_reports[$];
  int           reports_pending = 0;
  int           items_taken = 0;
  int           fails = 0;
  int           cycles = 0;
  bit           busy_in = 1'b0;
  logic         quiet;

  assign quiet = (items_taken >= 500) && (items_taken < 800);

  logic [DATA_BITS-1:0] word_mem [MEMW];
  bit                   word_set [MEMW];
  logic [DATA_BITS-1:0] bus_r = '0, mar_r = '0, mbr_r = '0, pc_r = '0;
  logic [DATA_BITS-1:0] d_r = '0, e_r = '0, p_r = '0, q_r = '0;
  bit                   flag_r = 1'b0, halt_r = 1'b0;

  initial begin
    for (int i = 0; i < MEMW; i++) word_set[i] = 1'b0;
  end

  function automatic void machine_apply(input bus_item_t it);
    logic [DATA_BITS-1:0] w, ma, mb, qt;
    step_report_t rep;
    if (it.func == FUNC_LOAD) begin
      word_mem[it.addr] = it.data;
      word_set[it.addr] = 1'b1;
      return;
    end
    rep = '0;
    if (!halt_r) begin
      w = word_mem[pc_r[PC_BITS-1:0]];
      pc_r = pc_r + 1;
      if (!w[DATA_BITS-1]) begin
        case (w)
          OP_MEM_READ:  mbr_r = word_mem[mar_r[PC_BITS-1:0]];
          OP_MEM_WRITE: begin
            word_mem[mar_r[PC_BITS-1:0]] = mbr_r;
            word_set[mar_r[PC_BITS-1:0]] = 1'b1;
          end
          OP_BRANCH:  if (!flag_r) pc_r = bus_r;
          OP_BUS_MAR: mar_r = bus_r;
          OP_BUS_MBR: mbr_r = bus_r;
          OP_BUS_PC:  pc_r = bus_r;
          OP_BUS_D:   d_r = bus_r;
          OP_BUS_E:   e_r = bus_r;
          OP_MAR_BUS: bus_r = mar_r;
          OP_MBR_BUS: bus_r = mbr_r;
          OP_PC_BUS:  bus_r = pc_r;
          OP_D_BUS:   bus_r = d_r;
          OP_E_BUS:   bus_r = e_r;
          OP_BUS_P:   p_r = bus_r;
          OP_BUS_Q:   q_r = bus_r;
          OP_ADD: begin
            bus_r = p_r + q_r;
            flag_r = bus_r[DATA_BITS-1];
          end
          OP_SUB: begin
            bus_r = p_r - q_r;
            flag_r = bus_r[DATA_BITS-1];
          end
          OP_MUL: bus_r = p_r * q_r;
          OP_DIV: begin
            ma = p_r[DATA_BITS-1] ? -p_r : p_r;
            mb = q_r[DATA_BITS-1] ? -q_r : q_r;
            if (mb == '0) begin
              bus_r = '0;
            end else begin
              qt = ma / mb;
              if (p_r[DATA_BITS-1] != q_r[DATA_BITS-1]) qt = -qt;
              bus_r = qt;
            end
          end
          OP_INPUT: bus_r = it.data;
          OP_OUTPUT: begin
            rep.has_output = 1'b1;
            rep.value = bus_r;
          end
          OP_HALT: halt_r = 1'b1;
          default: if (w >= OP_IMM_BASE && w <= OP_IMM_LAST) bus_r = w - OP_IMM_BASE;
        endcase
      end
    end
    rep.halted = halt_r;
    rep.pc = pc_r[PC_BITS-1:0];
    step_reports.push_back(rep);
    reports_pending++;
  endfunction

  task automatic flag_mismatch(input string field, input logic [DATA_BITS-1:0] got,
                               input logic [DATA_BITS-1:0] want);
    $display("mismatch %s: got %h, want %h", field, got, want);
    fails++;
  endtask

  always @(posedge clk) begin : monitor_blk
    step_report_t want;
    cycles++;
    if (rst_n && out_valid && out_ready) begin
      if (reports_pending == 0) begin
        flag_mismatch("result with no step pending", out_output_value, '0);
      end else begin
        want = step_reports.pop_front();
        reports_pending--;
        if (out_has_output !== want.has_output)
          flag_mismatch("has_output", DATA_BITS'(out_has_output),
                        DATA_BITS'(want.has_output));
        if (out_output_value !== want.value)
          flag_mismatch("output_value", out_output_value, want.value);
        if (out_halted !== want.halted)
          flag_mismatch("halted", DATA_BITS'(out_halted), DATA_BITS'(want.halted));
        if (out_program_counter !== want.pc)
          flag_mismatch("program_counter", DATA_BITS'(out_program_counter),
                        DATA_BITS'(want.pc));
      end
    end
    if (rst_n && in_valid && in_ready) begin
      machine_apply(pending[0]);
      pending.pop_front();
      busy_in = 1'b0;
      items_taken++;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin : driver_blk
    bus_item_t nxt;
    out_ready <= quiet || ($urandom_range(0, 99) >= 25);
    if (rst_n && !busy_in) begin
      if (pending.size() != 0 && (quiet || $urandom_range(0, 99) >= 25)) begin
        nxt = pending[0];
        in_valid        <= 1'b1;
        in_func         <= nxt.func;
        in_load_address <= nxt.addr;
        in_data_value   <= nxt.data;
        busy_in = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  function automatic logic [DATA_BITS-1:0] pick_word();
    int r;
    logic [DATA_BITS-1:0] w;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      case ($urandom_range(0, 20))
        0:  w = OP_MEM_READ;
        1:  w = OP_MEM_WRITE;
        2:  w = OP_BRANCH;
        3:  w = OP_BUS_MAR;
        4:  w = OP_BUS_MBR;
        5:  w = OP_BUS_PC;
        6:  w = OP_BUS_D;
        7:  w = OP_BUS_E;
        8:  w = OP_MAR_BUS;
        9:  w = OP_MBR_BUS;
        10: w = OP_PC_BUS;
        11: w = OP_D_BUS;
        12: w = OP_E_BUS;
        13: w = OP_BUS_P;
        14: w = OP_BUS_Q;
        15: w = OP_ADD;
        16: w = OP_SUB;
        17: w = OP_MUL;
        18: w = OP_DIV;
        19: w = OP_INPUT;
        default: w = OP_OUTPUT;
      endcase
    end else if (r < 85) begin
      w = $urandom_range(OP_IMM_BASE, OP_IMM_LAST);
    end else begin
      case ($urandom_range(0, 4))
        0: w = $urandom;
        1: w = OP_IMM_BASE - 1;
        2: w = OP_IMM_LAST + 1;
        3: w = $urandom_range(OP_DIV + 1, OP_INPUT - 1);
        default: w = $urandom_range(OP_MEM_WRITE + 1, OP_BRANCH - 1);
      endcase
    end
    if (w == OP_HALT) w = OP_HALT + 1;
    return w;
  endfunction

  task automatic send_item(input logic f, input logic [LADDR_BITS-1:0] a,
                           input logic [DATA_BITS-1:0] d);
    int goal;
    bus_item_t it;
    goal = items_taken + 1;
    it.func = f;
    it.addr = a;
    it.data = d;
    pending.push_back(it);
    wait (items_taken == goal);
  endtask

  // fill any word that the step would read before it is read
  task automatic step_machine(input logic [DATA_BITS-1:0] d, input bit allow_halt);
    logic [PC_BITS-1:0] at;
    if (!halt_r) begin
      at = pc_r[PC_BITS-1:0];
      if (!word_set[at] || (word_mem[at] == OP_HALT && !allow_halt))
        send_item(FUNC_LOAD, at, pick_word());
      if (word_mem[at] == OP_MEM_READ && !word_set[mar_r[PC_BITS-1:0]])
        send_item(FUNC_LOAD, mar_r[PC_BITS-1:0], $urandom);
    end
    send_item(FUNC_STEP, LADDR_BITS'($urandom_range(0, MEMW - 1)), d);
  endtask

  task automatic exec_word(input logic [DATA_BITS-1:0] w, input logic [DATA_BITS-1:0] d,
                           input bit allow_halt);
    send_item(FUNC_LOAD, pc_r[PC_BITS-1:0], w);
    step_machine(d, allow_halt);
  endtask

  initial begin : stimulus_blk
    int r;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // most negative over minus one, divide by zero, sign flag blocking a branch
    exec_word(OP_INPUT, 32'h8000_0000, 1'b0);
    exec_word(OP_BUS_P, $urandom, 1'b0);
    exec_word(OP_INPUT, 32'hFFFF_FFFF, 1'b0);
    exec_word(OP_BUS_Q, $urandom, 1'b0);
    exec_word(OP_DIV, $urandom, 1'b0);
    exec_word(OP_OUTPUT, $urandom, 1'b0);
    exec_word(OP_SUB, $urandom, 1'b0);
    exec_word(OP_BRANCH, $urandom, 1'b0);
    exec_word(OP_IMM_BASE, $urandom, 1'b0);
    exec_word(OP_BUS_Q, $urandom, 1'b0);
    exec_word(OP_DIV, $urandom, 1'b0);
    exec_word(OP_OUTPUT, $urandom, 1'b0);
    exec_word(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_item(FUNC_LOAD, LADDR_BITS'(MEMW - 1), 32'h7FFF_FFFF);

    while (items_taken < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 12) send_item(FUNC_LOAD, LADDR_BITS'($urandom_range(0, MEMW - 1)), $urandom);
      else if (r < 65) exec_word(pick_word(), $urandom, 1'b0);
      else step_machine($urandom, 1'b0);
    end

    exec_word(OP_HALT, $urandom, 1'b1);
    repeat (3) step_machine($urandom, 1'b1);
    send_item(FUNC_LOAD, LADDR_BITS'($urandom_range(0, MEMW - 1)), $urandom);
    step_machine($urandom, 1'b1);

    wait (reports_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bmis_pkg.sv
rtl/bmis_ram.sv
rtl/bmis_muldiv.sv
rtl/bus_machine_instruction_step.sv
tb/bus_machine_instruction_step_tb.sv
